>>> src/fthl_pkg.sv
// Shared constants and types for the flow table hash lookup block.
`timescale 1ns / 1ps
`default_nettype none

package fthl_pkg;

  // Table geometry. BUCKETS must be a power of two: the hash keeps only
  // the low bits of the product.
  localparam int unsigned BUCKETS          = 256;
  localparam int unsigned SLOTS_PER_BUCKET = 8;
  localparam int unsigned TOTAL_SLOTS      = BUCKETS * SLOTS_PER_BUCKET;

  localparam int unsigned BKT_W  = $clog2(BUCKETS);
  localparam int unsigned SLOT_W = $clog2(SLOTS_PER_BUCKET);
  localparam int unsigned CNT_W  = 12;
  localparam int unsigned WIN_W  = 16;
  localparam int unsigned ADDR_W = 32;
  localparam int unsigned PORT_W = 16;
  localparam int unsigned KEY_W  = 2 * ADDR_W + 2 * PORT_W;

  // Stream payload widths.
  localparam int unsigned IN_DATA_W  = KEY_W + WIN_W;
  localparam int unsigned OUT_DATA_W = 32;
  localparam int unsigned MODE_W     = 2;
  localparam int unsigned STAT_W     = 2;

  // Request modes. Code three is a no-op that reports a miss.
  localparam logic [MODE_W-1:0] MODE_INSERT = 2'd0;
  localparam logic [MODE_W-1:0] MODE_SEARCH = 2'd1;
  localparam logic [MODE_W-1:0] MODE_DELETE = 2'd2;

  typedef enum logic [STAT_W-1:0] {
    ST_OK   = 2'd0,
    ST_DUP  = 2'd1,
    ST_FULL = 2'd2,
    ST_MISS = 2'd3
  } fthl_status_e;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_HASH1,
    S_HASH2,
    S_HASH3,
    S_VRD,
    S_SCAN,
    S_DONE
  } fthl_state_e;

  typedef struct packed {
    logic [PORT_W-1:0] remote_port_num;
    logic [PORT_W-1:0] local_port_num;
    logic [ADDR_W-1:0] remote_addr;
    logic [ADDR_W-1:0] local_addr;
  } fthl_key_t;

  typedef struct packed {
    logic [WIN_W-1:0] window;
    fthl_key_t        key;
  } fthl_entry_t;

endpackage

`default_nettype wire

>>> src/flow_table_hash_lookup.sv
// Flow table with bounded hash buckets: insert, search and delete of flows.
`timescale 1ns / 1ps
`default_nettype none

// Usage
//   Slave stream carries one request per beat: tuser is the mode (insert,
//   search, delete), tdata the four-part flow key and the insert window.
//   Master stream returns one result per request: tuser is the status,
//   tdata the stored window and the flow count after the request.
// Sequencing
//   One request at a time. A request passes the hash states S_HASH1 to S_HASH3,
//   S_VRD to read the bucket's valid row, S_SCAN over the key memory (one slot
//   per cycle through its single read port, stopping at the first hit or the
//   last slot) and S_DONE to write back and load the result; then tready
//   rises again. A new request is taken only once the last one is through.
//   The slot scan, and any output stall in S_DONE, sets the rate.
// Reset
//   After rst_ni releases, the valid-row memory is swept to zero, one bucket
//   a cycle, tready low until all 256 are clear. Flow count starts at zero.
// Stall
//   The result sits in an output register. A new request is accepted while
//   it waits; the next result waits in S_DONE until the register drains.
module flow_table_hash_lookup (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  // request stream
  input  wire                          s_axis_tvalid,
  output logic                         s_axis_tready,
  // [31:0] local_addr, [63:32] remote_addr, [79:64] local_port_num,
  // [95:80] remote_port_num, [111:96] window_in
  input  wire  [fthl_pkg::IN_DATA_W-1:0] s_axis_tdata,
  // [1:0] mode
  input  wire  [fthl_pkg::MODE_W-1:0]    s_axis_tuser,
  // result stream
  output logic                         m_axis_tvalid,
  input  wire                          m_axis_tready,
  // [15:0] window_out, [27:16] flow_total, [31:28] zero
  output logic [fthl_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  // [1:0] status
  output logic [fthl_pkg::STAT_W-1:0]     m_axis_tuser
);
  import fthl_pkg::*;

  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(SLOTS_PER_BUCKET - 1);

  // Memories: per-bucket valid row, per-slot key and window.
  logic [SLOTS_PER_BUCKET-1:0] vld_mem [BUCKETS];
  fthl_entry_t                 ent_mem [TOTAL_SLOTS];

  fthl_state_e state_q, state_d;

  // Request registers
  fthl_key_t         key_q;
  logic [WIN_W-1:0]  win_q;
  logic [MODE_W-1:0] mode_q;
  logic [BKT_W-1:0]  hash_q, hash_d;

  // Scan state
  logic [SLOT_W-1:0]  slot_q, slot_d;
  logic               hit_q, hit_d;
  logic [SLOT_W-1:0]  hit_slot_q, hit_slot_d;
  logic [WIN_W-1:0]   hit_win_q, hit_win_d;
  logic [BKT_W-1:0]   clr_q, clr_d;
  logic [CNT_W-1:0]   cnt_q, cnt_d;

  // Memory ports
  logic                        vld_re;
  logic [SLOTS_PER_BUCKET-1:0] vld_rdata_q;
  logic                        vld_we;
  logic [BKT_W-1:0]            vld_waddr;
  logic [SLOTS_PER_BUCKET-1:0] vld_wdata;
  logic                        ent_re;
  logic [SLOT_W-1:0]           ent_rslot;
  fthl_entry_t                 ent_rdata_q;
  logic                        ent_we;

  // Output register
  logic                 out_vld_q, out_vld_d;
  fthl_status_e         out_st_q, out_st_d;
  logic [WIN_W-1:0]     out_win_q, out_win_d;
  logic [CNT_W-1:0]     out_cnt_q, out_cnt_d;
  logic                 out_free;

  // Hash operands, all taken modulo 2^BKT_W
  logic [BKT_W-1:0]   op_a, op_b;
  logic [2*BKT_W-1:0] prod;

  // Free slot search and final status
  logic                        bkt_full;
  logic [SLOT_W-1:0]           free_slot;
  fthl_status_e                fin_st;
  logic [SLOTS_PER_BUCKET-1:0] hit_mask, free_mask;

  logic in_acc;
  fthl_key_t in_key;

  assign in_key   = fthl_key_t'(s_axis_tdata[KEY_W-1:0]);
  assign in_acc   = s_axis_tvalid && s_axis_tready;
  assign out_free = !out_vld_q || m_axis_tready;

  // Shared multiplier for the three hash steps
  always_comb begin
    op_a = hash_q;
    op_b = BKT_W'(key_q.remote_addr[ADDR_W-1:ADDR_W-8]) + BKT_W'(1);
    unique case (state_q)
      S_HASH1: begin
        op_a = BKT_W'(key_q.local_addr[ADDR_W-1:ADDR_W-8]) + BKT_W'(1);
        op_b = BKT_W'(key_q.remote_addr[ADDR_W-1:ADDR_W-8]) + BKT_W'(1);
      end
      S_HASH2: op_b = BKT_W'(key_q.local_port_num) + BKT_W'(1);
      S_HASH3: op_b = BKT_W'(key_q.remote_port_num) + BKT_W'(1);
      default: ;
    endcase
  end
  assign prod = op_a * op_b;

  // Lowest free slot of the bucket
  always_comb begin
    free_slot = '0;
    for (int s = SLOTS_PER_BUCKET - 1; s >= 0; s--) begin
      if (!vld_rdata_q[s]) free_slot = SLOT_W'(s);
    end
  end
  assign bkt_full = &vld_rdata_q;

  always_comb begin
    hit_mask  = '0;
    free_mask = '0;
    hit_mask[hit_slot_q] = 1'b1;
    free_mask[free_slot] = 1'b1;
  end

  always_comb begin
    fin_st = ST_MISS;
    if (mode_q == MODE_INSERT) begin
      if (bkt_full)   fin_st = ST_FULL;
      else if (hit_q) fin_st = ST_DUP;
      else            fin_st = ST_OK;
    end else if (mode_q == MODE_SEARCH || mode_q == MODE_DELETE) begin
      if (hit_q) fin_st = ST_OK;
    end
  end

  // Control FSM
  always_comb begin
    state_d    = state_q;
    hash_d     = hash_q;
    slot_d     = slot_q;
    hit_d      = hit_q;
    hit_slot_d = hit_slot_q;
    hit_win_d  = hit_win_q;
    clr_d      = clr_q;
    cnt_d      = cnt_q;
    out_vld_d  = out_vld_q && !m_axis_tready;
    out_st_d   = out_st_q;
    out_win_d  = out_win_q;
    out_cnt_d  = out_cnt_q;
    s_axis_tready = 1'b0;
    vld_re     = 1'b0;
    vld_we     = 1'b0;
    vld_waddr  = hash_q;
    vld_wdata  = vld_rdata_q;
    ent_re     = 1'b0;
    ent_rslot  = slot_q;
    ent_we     = 1'b0;

    unique case (state_q)
      S_CLEAR: begin
        vld_we    = 1'b1;
        vld_waddr = clr_q;
        vld_wdata = '0;
        clr_d     = clr_q + BKT_W'(1);
        if (clr_q == BKT_W'(BUCKETS - 1)) state_d = S_IDLE;
      end
      S_IDLE: begin
        s_axis_tready = 1'b1;
        if (s_axis_tvalid) state_d = S_HASH1;
      end
      S_HASH1: begin
        hash_d  = prod[BKT_W-1:0];
        state_d = S_HASH2;
      end
      S_HASH2: begin
        hash_d  = prod[BKT_W-1:0];
        state_d = S_HASH3;
      end
      S_HASH3: begin
        hash_d  = prod[BKT_W-1:0];
        state_d = S_VRD;
      end
      S_VRD: begin
        // valid row and slot 0 come back together next cycle
        vld_re    = 1'b1;
        ent_re    = 1'b1;
        ent_rslot = '0;
        slot_d    = '0;
        hit_d     = 1'b0;
        state_d   = S_SCAN;
      end
      S_SCAN: begin
        if (vld_rdata_q[slot_q] && ent_rdata_q.key == key_q) begin
          hit_d      = 1'b1;
          hit_slot_d = slot_q;
          hit_win_d  = ent_rdata_q.window;
          state_d    = S_DONE;
        end else if (slot_q == LAST_SLOT) begin
          state_d = S_DONE;
        end else begin
          ent_re    = 1'b1;
          ent_rslot = slot_q + SLOT_W'(1);
          slot_d    = slot_q + SLOT_W'(1);
        end
      end
      S_DONE: begin
        if (out_free) begin
          out_vld_d = 1'b1;
          out_st_d  = fin_st;
          out_win_d = '0;
          if (mode_q == MODE_INSERT && fin_st == ST_OK) begin
            ent_we    = 1'b1;
            vld_we    = 1'b1;
            vld_wdata = vld_rdata_q | free_mask;
            cnt_d     = cnt_q + CNT_W'(1);
          end else if (mode_q == MODE_SEARCH && hit_q) begin
            out_win_d = hit_win_q;
          end else if (mode_q == MODE_DELETE && hit_q) begin
            out_win_d = hit_win_q;
            vld_we    = 1'b1;
            vld_wdata = vld_rdata_q & ~hit_mask;
            if (cnt_q != '0) cnt_d = cnt_q - CNT_W'(1);
          end
          out_cnt_d = cnt_d;
          state_d   = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_CLEAR;
      clr_q     <= '0;
      cnt_q     <= '0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      clr_q     <= clr_d;
      cnt_q     <= cnt_d;
      out_vld_q <= out_vld_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      key_q  <= in_key;
      win_q  <= s_axis_tdata[IN_DATA_W-1:KEY_W];
      mode_q <= s_axis_tuser;
    end
    hash_q     <= hash_d;
    slot_q     <= slot_d;
    hit_q      <= hit_d;
    hit_slot_q <= hit_slot_d;
    hit_win_q  <= hit_win_d;
    out_st_q   <= out_st_d;
    out_win_q  <= out_win_d;
    out_cnt_q  <= out_cnt_d;
  end

  // Valid-row memory
  always_ff @(posedge clk_i) begin
    if (vld_we) vld_mem[vld_waddr] <= vld_wdata;
    if (vld_re) vld_rdata_q <= vld_mem[hash_q];
  end

  // Key/window memory
  always_ff @(posedge clk_i) begin
    if (ent_we) ent_mem[{hash_q, free_slot}] <= '{window: win_q, key: key_q};
    if (ent_re) ent_rdata_q <= ent_mem[{hash_q, ent_rslot}];
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tuser  = out_st_q;
  assign m_axis_tdata  = {(OUT_DATA_W - CNT_W - WIN_W)'(0), out_cnt_q, out_win_q};

  // Checks
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(TOTAL_SLOTS))
    else $error("flow count beyond table size");

  a_cnt_only_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q != S_DONE |=> $stable(cnt_q))
    else $error("flow count moved outside write-back");

  a_done_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DONE && out_free) |=> (state_q == S_IDLE && m_axis_tvalid))
    else $error("write-back did not load a result");

  a_insert_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DONE && out_free && mode_q == MODE_INSERT && fin_st == ST_OK)
      |=> cnt_q == $past(cnt_q) + CNT_W'(1))
    else $error("successful insert did not bump count");

  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCAN) |=> !$past(in_acc))
    else $error("request accepted during scan");

endmodule

`default_nettype wire

>>> verif/tb_top.sv
// Self-checking testbench for the flow table hash lookup block.
`timescale 1ns / 1ps

module tb_top;
  import fthl_pkg::*;

  localparam logic [MODE_W-1:0] MODE_NOP = 2'd3;  // unused code, answered as a miss
  localparam int unsigned QUIET_LIMIT = 5000;     // cycles with no handshake at all
  localparam int unsigned TAIL_CYCLES = 40;       // cycles run on after the last result
  localparam int unsigned PHASE_ITEMS = 276;
  localparam int unsigned POOL_MAX    = 64;

  typedef struct {
    logic [MODE_W-1:0] mode;
    fthl_key_t         key;
    logic [WIN_W-1:0]  win;
    bit                hold;   // not a request: wait for the table to go quiet
    int unsigned       phase;
  } flow_req_t;

  typedef struct {
    fthl_status_e     status;
    logic [WIN_W-1:0] window;
    logic [CNT_W-1:0] total;
  } flow_result_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_axis_tvalid = 1'b0;
  wire  s_axis_tready;
  logic [IN_DATA_W-1:0] s_axis_tdata = '0;
  logic [MODE_W-1:0] s_axis_tuser = '0;
  wire  m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  wire  [OUT_DATA_W-1:0] m_axis_tdata;
  wire  [STAT_W-1:0] m_axis_tuser;

  flow_table_hash_lookup dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  // Shadow flow table
  bit               slot_used [TOTAL_SLOTS];
  fthl_key_t        slot_keys [TOTAL_SLOTS];
  logic [WIN_W-1:0] slot_win  [TOTAL_SLOTS];
  int unsigned      flows_held = 0;

  flow_req_t    pend_q[$];
  flow_result_t expect_q[$];
  fthl_key_t    key_pool[$];

  flow_req_t   shown_req;
  bit          req_shown = 1'b0;
  bit          drain_wait = 1'b0;
  int unsigned send_idle = 32;
  int unsigned recv_idle = 69;
  int unsigned quiet_cycles = 0;
  int unsigned err_cnt = 0;
  int unsigned results_seen = 0;

  function automatic int unsigned bucket_of_key(fthl_key_t k);
    logic [31:0] prod;
    prod = (32'(k.local_addr[31:24]) + 1) * (32'(k.remote_addr[31:24]) + 1);
    prod = prod * (32'(k.local_port_num) + 1);
    prod = prod * (32'(k.remote_port_num) + 1);
    return prod % BUCKETS;
  endfunction

  // Applies one request to the shadow table and returns what the block must answer.
  function automatic flow_result_t apply_flow_req(flow_req_t r);
    flow_result_t res;
    int unsigned  base;
    int           hit;
    int           free_slot;
    base = bucket_of_key(r.key) * SLOTS_PER_BUCKET;
    hit = -1;
    free_slot = -1;
    for (int s = 0; s < SLOTS_PER_BUCKET; s++) begin
      if (slot_used[base + s]) begin
        if (hit < 0 && slot_keys[base + s] == r.key) hit = s;
      end else if (free_slot < 0) begin
        free_slot = s;
      end
    end
    res.status = ST_MISS;
    res.window = '0;
    case (r.mode) inside
      MODE_INSERT: begin
        // a full bucket wins over a duplicate key
        if (free_slot < 0) begin
          res.status = ST_FULL;
        end else if (hit >= 0) begin
          res.status = ST_DUP;
        end else begin
          slot_used[base + free_slot] = 1'b1;
          slot_keys[base + free_slot] = r.key;
          slot_win[base + free_slot] = r.win;
          flows_held++;
          res.status = ST_OK;
        end
      end
      MODE_SEARCH, MODE_DELETE: begin
        if (hit >= 0) begin
          res.status = ST_OK;
          res.window = slot_win[base + hit];
          if (r.mode == MODE_DELETE) begin
            slot_used[base + hit] = 1'b0;
            if (flows_held > 0) flows_held--;
          end
        end
      end
      default: ;
    endcase
    res.total = flows_held[CNT_W-1:0];
    return res;
  endfunction

  task automatic flag_error(string msg);
    if (err_cnt < 10) $display("%s", msg);
    err_cnt++;
  endtask

  task automatic queue_req(logic [MODE_W-1:0] mode, fthl_key_t key, logic [WIN_W-1:0] win,
                           int unsigned phase);
    flow_req_t r;
    r.mode = mode;
    r.key = key;
    r.win = win;
    r.hold = 1'b0;
    r.phase = phase;
    pend_q.push_back(r);
  endtask

  task automatic queue_hold();
    flow_req_t r;
    r = '{default: '0};
    r.hold = 1'b1;
    pend_q.push_back(r);
  endtask

  // New keys: uniform, forced into bucket zero, or from a narrow range that
  // piles many flows onto a few buckets.
  function automatic fthl_key_t fresh_key();
    fthl_key_t   k;
    int unsigned pick;
    k.local_addr = $urandom;
    k.remote_addr = $urandom;
    k.local_port_num = 16'($urandom);
    k.remote_port_num = 16'($urandom);
    pick = $urandom_range(99);
    if (pick >= 50 && pick < 65) begin
      k.local_port_num[7:0] = 8'hFF;
    end else if (pick >= 65) begin
      k.local_addr[31:24] = 8'($urandom_range(3));
      k.remote_addr[31:24] = 8'($urandom_range(3));
      k.local_port_num = 16'($urandom_range(7));
      k.remote_port_num = 16'($urandom_range(7));
    end
    return k;
  endfunction

  function automatic fthl_key_t pick_key();
    fthl_key_t k;
    if (key_pool.size() != 0 && $urandom_range(99) < 65) begin
      k = key_pool[$urandom_range(key_pool.size() - 1)];
    end else begin
      k = fresh_key();
      if (key_pool.size() >= POOL_MAX) key_pool[$urandom_range(POOL_MAX - 1)] = k;
      else key_pool.push_back(k);
    end
    return k;
  endfunction

  // Driver: presents requests at the falling edge, holds each until taken.
  always @(negedge clk_i) begin
    flow_req_t nxt;
    bit        go;
    go = 1'b0;
    if (rst_ni && !req_shown) begin
      if (drain_wait && expect_q.size() == 0) drain_wait = 1'b0;
      while (!drain_wait && pend_q.size() != 0 && pend_q[0].hold) begin
        void'(pend_q.pop_front());
        drain_wait = (expect_q.size() != 0);
      end
      if (!drain_wait && pend_q.size() != 0 && $urandom_range(99) >= send_idle) begin
        nxt = pend_q.pop_front();
        case (nxt.phase)
          0: begin send_idle = 32; recv_idle = 69; end
          1: begin send_idle = 69; recv_idle = 32; end
          default: begin send_idle = 0; recv_idle = 0; end
        endcase
        shown_req = nxt;
        req_shown = 1'b1;
        go = 1'b1;
      end
    end
    if (go) begin
      s_axis_tvalid <= 1'b1;
      s_axis_tdata <= {nxt.win, nxt.key};
      s_axis_tuser <= nxt.mode;
    end else if (!req_shown) begin
      s_axis_tvalid <= 1'b0;
    end
    m_axis_tready <= ($urandom_range(99) >= recv_idle);
  end

  // Monitor: checks results first, then records newly taken requests.
  always @(posedge clk_i) begin
    flow_result_t exp_res;
    if (rst_ni) begin
      quiet_cycles++;
      if (m_axis_tvalid && m_axis_tready) begin
        quiet_cycles = 0;
        results_seen++;
        if (expect_q.size() == 0) begin
          flag_error($sformatf("result %0d arrived with no request outstanding", results_seen));
        end else begin
          exp_res = expect_q.pop_front();
          if (m_axis_tuser !== exp_res.status || m_axis_tdata[15:0] !== exp_res.window ||
              m_axis_tdata[27:16] !== exp_res.total || m_axis_tdata[31:28] !== 4'd0) begin
            flag_error($sformatf(
              {"result %0d: status exp %0d got %0d, window exp %h got %h, ",
               "flows exp %0d got %0d, pad %h"},
              results_seen, exp_res.status, m_axis_tuser, exp_res.window, m_axis_tdata[15:0],
              exp_res.total, m_axis_tdata[27:16], m_axis_tdata[31:28]));
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        quiet_cycles = 0;
        expect_q.push_back(apply_flow_req(shown_req));
        req_shown = 1'b0;
      end
    end
  end

  initial begin
    while (quiet_cycles < QUIET_LIMIT) @(negedge clk_i);
    $display("FAIL flow_table_hash_lookup");
    $finish;
  end

  initial begin
    fthl_key_t   zero_key;
    fthl_key_t   ones_key;
    fthl_key_t   bz [8];
    int unsigned roll;
    logic [MODE_W-1:0] mode;
    logic [WIN_W-1:0]  win;

    zero_key = '0;
    ones_key = '1;
    // local port 255 makes the hash a multiple of 256: all land in bucket zero
    foreach (bz[i]) begin
      bz[i].local_addr = $urandom;
      bz[i].remote_addr = $urandom;
      bz[i].local_port_num = 16'h00FF;
      bz[i].remote_port_num = 16'($urandom);
      key_pool.push_back(bz[i]);
    end
    key_pool.push_back(zero_key);
    key_pool.push_back(ones_key);

    // directed: misses on an empty table, duplicate, mode three, full bucket
    queue_req(MODE_SEARCH, zero_key, 16'h0000, 0);
    queue_req(MODE_DELETE, zero_key, 16'hFFFF, 0);
    queue_req(MODE_INSERT, zero_key, 16'hFFFF, 0);
    queue_req(MODE_INSERT, zero_key, 16'h1234, 0);
    queue_req(MODE_SEARCH, zero_key, 16'h0000, 0);
    queue_req(MODE_INSERT, ones_key, 16'h0000, 0);   // bucket zero, window zero
    queue_req(MODE_NOP, ones_key, 16'hFFFF, 0);
    for (int i = 0; i < 7; i++) queue_req(MODE_INSERT, bz[i], 16'($urandom), 0);
    queue_req(MODE_INSERT, bz[7], 16'hA5A5, 0);      // bucket already full
    queue_req(MODE_INSERT, ones_key, 16'h5A5A, 0);   // present but full
    queue_req(MODE_SEARCH, ones_key, 16'h0000, 0);
    queue_req(MODE_DELETE, ones_key, 16'h0000, 0);   // zero window still drops the count
    queue_req(MODE_SEARCH, ones_key, 16'h0000, 0);
    queue_req(MODE_INSERT, bz[7], 16'hA5A5, 0);      // reuses lowest free slot
    queue_req(MODE_DELETE, zero_key, 16'h0000, 0);
    queue_req(MODE_DELETE, bz[0], 16'h0000, 0);
    queue_req(MODE_SEARCH, bz[7], 16'h0000, 0);
    queue_hold();

    for (int unsigned ph = 0; ph < 3; ph++) begin
      for (int unsigned n = 0; n < PHASE_ITEMS; n++) begin
        roll = $urandom_range(99);
        if (roll < 45) mode = MODE_INSERT;
        else if (roll < 70) mode = MODE_SEARCH;
        else if (roll < 95) mode = MODE_DELETE;
        else mode = MODE_NOP;
        win = ($urandom_range(9) == 0) ? 16'h0000 : 16'($urandom);
        queue_req(mode, pick_key(), win, ph);
      end
      queue_hold();
    end

    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    while (pend_q.size() != 0 || req_shown) @(negedge clk_i);
    while (expect_q.size() != 0) @(negedge clk_i);
    repeat (TAIL_CYCLES) @(negedge clk_i);
    if (err_cnt == 0) begin
      $display("PASS flow_table_hash_lookup");
    end else begin
      $display("FAIL flow_table_hash_lookup");
    end
    $finish;
  end

endmodule
